// ===== rtl/sals_pkg.sv =====
package sals_pkg;

	// default geometry
	localparam int OFS_W_DEF = 5;
	localparam int SETS_DEF  = 64;
	localparam int WAYS_DEF  = 4;

	// fixed field widths
	localparam int ADDR_W  = 32;
	localparam int STAMP_W = 32;

	// command codes
	typedef enum logic [2:0] {
		CMD_READ       = 3'd0,
		CMD_WRITE      = 3'd1,
		CMD_FILL       = 3'd2,
		CMD_INVAL      = 3'd3,
		CMD_MARK_DIRTY = 3'd4
	} command_t;

	// one result beat
	typedef struct packed {
		logic              hit;
		logic              line_dirty;
		logic              installed;
		logic [ADDR_W-1:0] victim_address;
	} result_t;

endpackage

// ===== rtl/sals_ram.sv =====
module sals_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/sals_update.sv =====
module sals_update #(
	parameter int OFS_W       = sals_pkg::OFS_W_DEF,
	parameter int SET_W       = $clog2(sals_pkg::SETS_DEF + 1) - 1,
	parameter int WAYS        = sals_pkg::WAYS_DEF,
	localparam int TAG_W      = sals_pkg::ADDR_W - OFS_W - SET_W,
	localparam int ENTRY_W    = TAG_W + sals_pkg::STAMP_W + 2,
	localparam int ROW_W      = WAYS * ENTRY_W
) (
	input  sals_pkg::command_t              cmd,
	input  logic [sals_pkg::ADDR_W-1:0]     address,
	input  logic [sals_pkg::STAMP_W-1:0]    clock,
	input  logic [ROW_W-1:0]                row_in,
	output logic [ROW_W-1:0]                row_out,
	output sals_pkg::result_t               result
);

	localparam int SHIFT     = OFS_W + SET_W;
	localparam int DIRTY_POS = TAG_W + sals_pkg::STAMP_W;
	localparam int VALID_POS = TAG_W + sals_pkg::STAMP_W + 1;
	localparam logic [sals_pkg::ADDR_W-1:0] SET_MASK =
		sals_pkg::ADDR_W'(((64'd1 << SET_W) - 64'd1) << OFS_W);

	logic [TAG_W-1:0]             tag;
	logic [TAG_W-1:0]             tag_w     [WAYS];
	logic [sals_pkg::STAMP_W-1:0] stamp_w   [WAYS];
	logic [WAYS-1:0]              valid_w;
	logic [WAYS-1:0]              dirty_w;
	logic [TAG_W-1:0]             tag_n     [WAYS];
	logic [sals_pkg::STAMP_W-1:0] stamp_n   [WAYS];
	logic [WAYS-1:0]              valid_n;
	logic [WAYS-1:0]              dirty_n;
	logic [WAYS-1:0]              match;
	logic [WAYS-1:0]              first_oh;
	logic [WAYS-1:0]              free;
	logic [WAYS-1:0]              free_oh;
	logic [WAYS-1:0]              lru_oh;
	logic [WAYS-1:0]              match_n;
	logic [WAYS-1:0]              first_n_oh;
	logic [TAG_W-1:0]             lru_tag;
	logic [sals_pkg::STAMP_W-1:0] clock_inc;

	assign tag       = address[sals_pkg::ADDR_W-1:SHIFT];
	assign clock_inc = clock + sals_pkg::STAMP_W'(1);

	// unpack the set and look up the tag
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			tag_w[w]   = row_in[w*ENTRY_W +: TAG_W];
			stamp_w[w] = row_in[w*ENTRY_W + TAG_W +: sals_pkg::STAMP_W];
			dirty_w[w] = row_in[w*ENTRY_W + DIRTY_POS];
			valid_w[w] = row_in[w*ENTRY_W + VALID_POS];
			match[w]   = valid_w[w] && (tag_w[w] == tag);
		end
	end

	// lowest matching way and lowest free way
	assign first_oh = match & (~match + WAYS'(1));
	assign free     = ~valid_w;
	assign free_oh  = free & (~free + WAYS'(1));

	// lru: strictly older than lower ways, no newer than higher ways
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			lru_oh[i] = 1'b1;
			for (int j = 0; j < WAYS; j++) begin
				if (j < i && !(stamp_w[i] < stamp_w[j])) begin
					lru_oh[i] = 1'b0;
				end
				if (j > i && !(stamp_w[i] <= stamp_w[j])) begin
					lru_oh[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		lru_tag = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (lru_oh[w]) begin
				lru_tag = lru_tag | tag_w[w];
			end
		end
	end

	// modify the set per command
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			tag_n[w]   = tag_w[w];
			stamp_n[w] = stamp_w[w];
			valid_n[w] = valid_w[w];
			dirty_n[w] = dirty_w[w];
			unique case (cmd)
				sals_pkg::CMD_READ, sals_pkg::CMD_WRITE: begin
					if (first_oh[w]) begin
						stamp_n[w] = clock_inc;
						if (cmd == sals_pkg::CMD_WRITE) begin
							dirty_n[w] = 1'b1;
						end
					end
				end
				sals_pkg::CMD_FILL: begin
					if (free_oh[w]) begin
						valid_n[w] = 1'b1;
						dirty_n[w] = 1'b0;
						tag_n[w]   = tag;
						stamp_n[w] = clock;
					end
				end
				sals_pkg::CMD_INVAL: begin
					if (first_oh[w]) begin
						valid_n[w] = 1'b0;
						dirty_n[w] = 1'b0;
						stamp_n[w] = '0;
					end
				end
				sals_pkg::CMD_MARK_DIRTY: begin
					if (match[w]) begin
						dirty_n[w] = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// pack the set and look up again for the final dirty bit
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			row_out[w*ENTRY_W +: ENTRY_W] = {valid_n[w], dirty_n[w], stamp_n[w], tag_n[w]};
			match_n[w] = valid_n[w] && (tag_n[w] == tag);
		end
	end

	assign first_n_oh = match_n & (~match_n + WAYS'(1));

	// result beat
	always_comb begin
		result.hit            = |match;
		result.line_dirty     = |(first_n_oh & dirty_n);
		result.installed      = (cmd == sals_pkg::CMD_FILL) && (|free);
		result.victim_address = '0;
		if (cmd == sals_pkg::CMD_FILL && !(|free)) begin
			result.victim_address = (sals_pkg::ADDR_W'(lru_tag) << SHIFT) | (address & SET_MASK);
		end
	end

endmodule

// ===== rtl/set_assoc_lru_tag_store.sv =====
// Tag store of a set-associative write-back cache with timestamp LRU.
// Command channel: a beat (command, address) is taken at a rising edge with
// start high and busy low. Commands: read, write, fill, invalidate, mark dirty.
// Result channel: done is high for exactly one cycle with hit, line_dirty,
// installed and victim_address; the receiver cannot stall it and must take
// the beat in that cycle.
// An accepted command sets pend_s1, which in turn sets done_q; done and the
// result payload are registered. One set is one row of a single-port-write,
// registered-read memory: the row is read when the command is taken, then
// the tags are compared, the LRU way is picked and the row is written back.
// No new command is taken while one is pending; busy is high in the cycle after
// each accepted command, which also keeps row accesses from overlapping.
// Reset: arst_n clears the access clock and control state, then a clearing
// pass writes every set row to zero, with busy held high until it ends.
module set_assoc_lru_tag_store #(
	parameter int OFS_W = sals_pkg::OFS_W_DEF,
	parameter int SETS  = sals_pkg::SETS_DEF,
	parameter int WAYS  = sals_pkg::WAYS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  command,
	input  logic [sals_pkg::ADDR_W-1:0] address,
	output logic                        done,
	output logic                        hit,
	output logic                        line_dirty,
	output logic                        installed,
	output logic [sals_pkg::ADDR_W-1:0] victim_address
);

	localparam int SET_W    = $clog2(SETS + 1) - 1;
	localparam int ROWS     = 1 << SET_W;
	localparam int IDX_W    = (SET_W > 0) ? SET_W : 1;
	localparam int TAG_W    = sals_pkg::ADDR_W - OFS_W - SET_W;
	localparam int ROW_W    = WAYS * (TAG_W + sals_pkg::STAMP_W + 2);
	localparam logic [sals_pkg::ADDR_W-1:0] IDX_MASK =
		sals_pkg::ADDR_W'((64'd1 << SET_W) - 64'd1);

	logic                         accept;
	logic                         pend_s1;
	sals_pkg::command_t           cmd_s1;
	logic [sals_pkg::ADDR_W-1:0]  addr_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [IDX_W-1:0]             rd_idx;
	logic                         clr_active_q;
	logic [IDX_W-1:0]             clr_idx_q;
	logic [sals_pkg::STAMP_W-1:0] clock_q;
	logic                         done_q;
	sals_pkg::result_t            res_q;
	sals_pkg::result_t            res_s1;
	logic [ROW_W-1:0]             row_rd;
	logic [ROW_W-1:0]             row_new;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_idx;
	logic [ROW_W-1:0]             wr_row;

	assign busy   = clr_active_q | pend_s1;
	assign accept = start && !busy;
	assign rd_idx = IDX_W'((address >> OFS_W) & IDX_MASK);

	// write port: clearing pass or read-modify-write of the looked-up set
	assign wr_en  = clr_active_q | pend_s1;
	assign wr_idx = clr_active_q ? clr_idx_q : idx_s1;
	assign wr_row = clr_active_q ? '0 : row_new;

	sals_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx),
		.wr_data (wr_row),
		.rd_en   (accept),
		.rd_addr (rd_idx),
		.rd_data (row_rd)
	);

	sals_update #(
		.OFS_W (OFS_W),
		.SET_W (SET_W),
		.WAYS  (WAYS)
	) u_update (
		.cmd     (cmd_s1),
		.address (addr_s1),
		.clock   (clock_q),
		.row_in  (row_rd),
		.row_out (row_new),
		.result  (res_s1)
	);

	// control: clearing pass, stage valid, access clock, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1      <= 1'b0;
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
			clock_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			pend_s1 <= accept;
			done_q  <= pend_s1;
			if (clr_active_q) begin
				if (clr_idx_q == IDX_W'(ROWS - 1)) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
				end
			end
			if (pend_s1 && (cmd_s1 == sals_pkg::CMD_READ || cmd_s1 == sals_pkg::CMD_WRITE)) begin
				clock_q <= clock_q + sals_pkg::STAMP_W'(1);
			end
		end
	end

	// command beat and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= sals_pkg::command_t'(command);
			addr_s1 <= address;
			idx_s1  <= rd_idx;
		end
		if (pend_s1) begin
			res_q <= res_s1;
		end
	end

	assign done           = done_q;
	assign hit            = res_q.hit;
	assign line_dirty     = res_q.line_dirty;
	assign installed      = res_q.installed;
	assign victim_address = res_q.victim_address;

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// geometry as the block is built
	localparam int ADDR_W      = sals_pkg::ADDR_W;
	localparam int OFS_W       = sals_pkg::OFS_W_DEF;
	localparam int WAYS        = sals_pkg::WAYS_DEF;
	localparam int SET_W       = $clog2(sals_pkg::SETS_DEF + 1) - 1;
	localparam int LINES       = (1 << SET_W) * WAYS;
	localparam int TAG_W       = ADDR_W - OFS_W - SET_W;
	localparam int BLK_W       = ADDR_W - OFS_W;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_RANDOM  = 1200;

	// command codes with no function
	localparam logic [2:0] CMD_SPARE_5 = 3'd5;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	// fixed outcomes used by the directed rows
	localparam sals_pkg::result_t RES_MISS   = '0;
	localparam sals_pkg::result_t RES_PLACED = {3'b001, {ADDR_W{1'b0}}};

	typedef struct {
		logic [2:0]        cmd;
		logic [ADDR_W-1:0] addr;
		bit                typed;
		sals_pkg::result_t res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        command;
	logic [ADDR_W-1:0] address;
	logic              done;
	logic              hit;
	logic              line_dirty;
	logic              installed;
	logic [ADDR_W-1:0] victim_address;

	// mirror of the tag store
	logic             way_valid [LINES];
	logic [TAG_W-1:0] way_tag   [LINES];
	logic             way_dirty [LINES];
	logic [31:0]      way_stamp [LINES];
	logic [BLK_W-1:0] way_block [LINES];
	logic [31:0]      access_count;

	sals_pkg::result_t lookup_results[$];
	stim_row_t         directed_rows[$];
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;

	logic [TAG_W-1:0] tag_pool [6];
	logic [SET_W-1:0] hot_sets [4];

	set_assoc_lru_tag_store #(
		.OFS_W(OFS_W),
		.SETS(sals_pkg::SETS_DEF),
		.WAYS(WAYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.address(address),
		.done(done),
		.hit(hit),
		.line_dirty(line_dirty),
		.installed(installed),
		.victim_address(victim_address)
	);

	always #10 clk = ~clk;

	// first valid way holding the tag, WAYS if none
	function automatic int unsigned find_way(input int unsigned base,
			input logic [TAG_W-1:0] tg);
		for (int unsigned w = 0; w < WAYS; w++) begin
			if (way_valid[base + w] && way_tag[base + w] == tg)
				return w;
		end
		return WAYS;
	endfunction

	// run one command against the mirror and return its lookup result
	function automatic sals_pkg::result_t apply_command(input logic [2:0] cmd,
			input logic [ADDR_W-1:0] addr);
		int unsigned       base;
		int unsigned       w;
		int unsigned       lru;
		logic [TAG_W-1:0]  tg;
		bit                placed;
		sals_pkg::result_t r;
		tg     = TAG_W'(addr >> (OFS_W + SET_W));
		base   = ((addr >> OFS_W) & ((1 << SET_W) - 1)) * WAYS;
		r      = '0;
		lru    = 0;
		placed = 1'b0;
		w      = find_way(base, tg);
		r.hit  = (w < WAYS);
		case (cmd)
			sals_pkg::CMD_READ, sals_pkg::CMD_WRITE: begin
				access_count = access_count + 32'd1;
				if (r.hit) begin
					way_stamp[base + w] = access_count;
					if (cmd == sals_pkg::CMD_WRITE)
						way_dirty[base + w] = 1'b1;
				end
			end
			sals_pkg::CMD_FILL: begin
				// first free way, else report the oldest stamp
				for (int unsigned i = 0; i < WAYS; i++) begin
					if (!way_valid[base + i]) begin
						way_valid[base + i] = 1'b1;
						way_tag[base + i]   = tg;
						way_dirty[base + i] = 1'b0;
						way_stamp[base + i] = access_count;
						way_block[base + i] = addr[ADDR_W-1:OFS_W];
						placed = 1'b1;
						break;
					end
					if (way_stamp[base + i] < way_stamp[base + lru])
						lru = i;
				end
				if (placed)
					r.installed = 1'b1;
				else
					r.victim_address = {way_block[base + lru], {OFS_W{1'b0}}};
			end
			sals_pkg::CMD_INVAL: begin
				if (r.hit) begin
					way_valid[base + w] = 1'b0;
					way_dirty[base + w] = 1'b0;
					way_stamp[base + w] = '0;
				end
			end
			sals_pkg::CMD_MARK_DIRTY: begin
				for (int unsigned i = 0; i < WAYS; i++) begin
					if (way_valid[base + i] && way_tag[base + i] == tg)
						way_dirty[base + i] = 1'b1;
				end
			end
			default: begin
			end
		endcase
		w = find_way(base, tg);
		r.line_dirty = (w < WAYS) ? way_dirty[base + w] : 1'b0;
		return r;
	endfunction

	task automatic add_row(input logic [2:0] cmd, input logic [ADDR_W-1:0] addr,
			input bit typed, input sals_pkg::result_t res);
		stim_row_t row;
		row.cmd   = cmd;
		row.addr  = addr;
		row.typed = typed;
		row.res   = res;
		directed_rows.push_back(row);
	endtask

	// drive one command beat from a falling edge, return at the falling edge after it is taken
	task automatic send_command(input logic [2:0] cmd, input logic [ADDR_W-1:0] addr,
			input bit typed, input sals_pkg::result_t typed_res);
		sals_pkg::result_t r;
		start   <= 1'b1;
		command <= cmd;
		address <= addr;
		do
			@(posedge clk);
		while (busy);
		r = apply_command(cmd, addr);
		lookup_results.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	// random gap on the command side
	task automatic maybe_idle(input bit allowed);
		if (allowed && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// hold off until every outstanding lookup has returned
	task automatic drain_lookups();
		start <= 1'b0;
		do
			@(negedge clk);
		while (lookup_results.size() != 0);
	endtask

	function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// compare each result beat with the oldest outstanding lookup
	always @(posedge clk) begin
		sals_pkg::result_t want;
		if (done === 1'b1) begin
			if (lookup_results.size() == 0) begin
				$display("%0t: result beat with nothing outstanding, actual %0b %0b %0b %0h",
					$time, hit, line_dirty, installed, victim_address);
				fail_count++;
			end else begin
				want = lookup_results.pop_front();
				check_field("hit", ADDR_W'(want.hit), ADDR_W'(hit));
				check_field("line_dirty", ADDR_W'(want.line_dirty), ADDR_W'(line_dirty));
				check_field("installed", ADDR_W'(want.installed), ADDR_W'(installed));
				check_field("victim_address", want.victim_address, victim_address);
			end
		end
	end

	// run length guard
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("set_assoc_lru_tag_store regression: fail");
		$finish;
	end

	// stimulus
	initial begin
		logic [2:0]        cmd;
		logic [ADDR_W-1:0] addr;
		logic [TAG_W-1:0]  tg;
		logic [SET_W-1:0]  set_idx;
		logic [OFS_W-1:0]  ofs;
		int unsigned       pick;
		bit                quiet;

		arst_n  <= 1'b0;
		start   <= 1'b0;
		command <= sals_pkg::CMD_READ;
		address <= '0;
		for (int i = 0; i < LINES; i++) begin
			way_valid[i] = 1'b0;
			way_dirty[i] = 1'b0;
			way_stamp[i] = '0;
		end
		access_count = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty store, extremes of the address
		add_row(sals_pkg::CMD_READ,       32'h0000_0000, 1'b1, RES_MISS);
		add_row(sals_pkg::CMD_WRITE,      32'hFFFF_FFFF, 1'b1, RES_MISS);
		add_row(CMD_SPARE_7,              32'h0000_0000, 1'b1, RES_MISS);
		add_row(sals_pkg::CMD_MARK_DIRTY, 32'h0000_0000, 1'b1, RES_MISS);
		add_row(sals_pkg::CMD_INVAL,      32'hFFFF_FFFF, 1'b1, RES_MISS);
		add_row(sals_pkg::CMD_FILL,       32'hFFFF_FFFF, 1'b1, RES_PLACED);
		add_row(sals_pkg::CMD_READ,       32'hFFFF_FFE0, 1'b0, '0);
		add_row(sals_pkg::CMD_WRITE,      32'hFFFF_FFFF, 1'b0, '0);
		add_row(CMD_SPARE_5,              32'hFFFF_FFFF, 1'b0, '0);
		// fill set zero to capacity
		add_row(sals_pkg::CMD_FILL,       32'h0000_0000, 1'b1, RES_PLACED);
		add_row(sals_pkg::CMD_FILL,       32'h0000_0800, 1'b1, RES_PLACED);
		add_row(sals_pkg::CMD_FILL,       32'h0000_1000, 1'b1, RES_PLACED);
		add_row(sals_pkg::CMD_FILL,       32'h0000_181F, 1'b1, RES_PLACED);
		add_row(sals_pkg::CMD_READ,       32'h0000_0800, 1'b0, '0);
		add_row(sals_pkg::CMD_WRITE,      32'h0000_0004, 1'b0, '0);
		// full set: victim with a stamp tie, then repeated
		add_row(sals_pkg::CMD_FILL,       32'h0000_2000, 1'b0, '0);
		add_row(sals_pkg::CMD_FILL,       32'h0000_2000, 1'b0, '0);
		add_row(sals_pkg::CMD_INVAL,      32'h0000_1000, 1'b0, '0);
		// second copy of a present block, then drop the first one
		add_row(sals_pkg::CMD_FILL,       32'h0000_0000, 1'b0, '0);
		add_row(sals_pkg::CMD_MARK_DIRTY, 32'h0000_0800, 1'b0, '0);
		add_row(sals_pkg::CMD_INVAL,      32'h0000_0000, 1'b0, '0);
		add_row(CMD_SPARE_6,              32'h0000_0000, 1'b0, '0);
		add_row(sals_pkg::CMD_FILL,       32'hAAAA_AAAA, 1'b1, RES_PLACED);
		add_row(sals_pkg::CMD_READ,       32'h5555_5555, 1'b1, RES_MISS);

		foreach (directed_rows[i]) begin
			send_command(directed_rows[i].cmd, directed_rows[i].addr,
				directed_rows[i].typed, directed_rows[i].res);
			maybe_idle(1'b1);
		end
		drain_lookups();

		// random traffic, mostly on a few hot sets with a small tag pool
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 6; i++)
			tag_pool[i] = TAG_W'($urandom);
		hot_sets[0] = '0;
		hot_sets[1] = '1;
		hot_sets[2] = SET_W'($urandom);
		hot_sets[3] = SET_W'($urandom);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 28)
				cmd = sals_pkg::CMD_READ;
			else if (pick < 48)
				cmd = sals_pkg::CMD_WRITE;
			else if (pick < 70)
				cmd = sals_pkg::CMD_FILL;
			else if (pick < 85)
				cmd = sals_pkg::CMD_INVAL;
			else if (pick < 95)
				cmd = sals_pkg::CMD_MARK_DIRTY;
			else
				cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));

			tg      = tag_pool[$urandom_range(0, 5)];
			set_idx = ($urandom_range(0, 99) < 80) ? hot_sets[$urandom_range(0, 3)]
				: SET_W'($urandom);
			ofs     = OFS_W'($urandom);
			addr    = {tg, set_idx, ofs};
			// noise: any address at all
			if ($urandom_range(0, 99) < 10)
				addr = $urandom;

			send_command(cmd, addr, 1'b0, '0);
			quiet = (n >= 400 && n < 700);
			if (n == 800)
				drain_lookups();
			else
				maybe_idle(!quiet);
		end

		// wind down
		drain_lookups();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("set_assoc_lru_tag_store regression: pass");
		else
			$display("set_assoc_lru_tag_store regression: fail");
		$finish;
	end

endmodule
